@@ sv/iot_pkg.sv @@
// Shared widths, default sizes and request and reply codes for the open inode table.
package iot_pkg;

  localparam int ACT_W    = 2;
  localparam int INODE_W  = 10;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 3;
  localparam int BLOCK_W  = 11;
  localparam int OFFSET_W = 12;
  localparam int COUNT_W  = 16;

  localparam int SLOTS_DEF           = 64;
  localparam int INODES_IN_BLOCK_DEF = 64;
  localparam int INODE_BYTES_DEF     = 64;

  typedef enum logic [ACT_W-1:0] {
    ACT_GET      = 2'd0,
    ACT_PUT      = 2'd1,
    ACT_CLEAR    = 2'd2,
    ACT_RESERVED = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT     = 3'd0,
    ST_LOAD    = 3'd1,
    ST_FULL    = 3'd2,
    ST_OPEN    = 3'd3,
    ST_WB      = 3'd4,
    ST_IGNORED = 3'd5,
    ST_CLEARED = 3'd6
  } status_t;

endpackage

@@ sv/iot_loc.sv @@
// Three-stage unit that turns an inode number into its disk block and byte offset.
module iot_loc #(
  parameter int INODES_IN_BLOCK = iot_pkg::INODES_IN_BLOCK_DEF,
  parameter int INODE_BYTES     = iot_pkg::INODE_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [iot_pkg::INODE_W-1:0]   inode,
  input  logic [iot_pkg::BLOCK_W-1:0]   first_block,
  output logic                          done,
  output logic [iot_pkg::BLOCK_W-1:0]   block_number,
  output logic [iot_pkg::OFFSET_W-1:0]  byte_offset
);
  import iot_pkg::*;

  // The quotient is taken by a rounded-up reciprocal; with this shift it is
  // exact for every inode number and every divisor in range.
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam longint RECIP   = ((64'd1 << RECIP_SHIFT) + INODES_IN_BLOCK - 1) / INODES_IN_BLOCK;
  localparam int PROD_W      = INODE_W + RECIP_W;
  localparam int QD_W        = INODE_W + 9;
  localparam int REM_W       = 9;
  localparam int OFFM_W      = REM_W + 9;

  logic [2:0]              v_r;
  logic [PROD_W-1:0]       prod_r;
  logic [INODE_W-1:0]      x1_r, x2_r;
  logic [BLOCK_W-1:0]      f1_r, f2_r;
  logic [INODE_W-1:0]      q2_r, qd2_r;
  logic [BLOCK_W-1:0]      blk_r;
  logic [OFFSET_W-1:0]     off_r;
  logic [INODE_W-1:0]      q1;
  logic [REM_W-1:0]        rem2;

  assign q1   = prod_r[RECIP_SHIFT +: INODE_W];
  assign rem2 = REM_W'(x2_r - qd2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[1:0], start};
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(inode) * PROD_W'(RECIP);
    x1_r   <= inode;
    f1_r   <= first_block;
    q2_r   <= q1;
    qd2_r  <= INODE_W'(QD_W'(q1) * QD_W'(INODES_IN_BLOCK));
    x2_r   <= x1_r;
    f2_r   <= f1_r;
    blk_r  <= BLOCK_W'(BLOCK_W'(q2_r) + f2_r);
    off_r  <= OFFSET_W'(OFFM_W'(rem2) * OFFM_W'(INODE_BYTES));
  end

  assign done         = v_r[2];
  assign block_number = blk_r;
  assign byte_offset  = off_r;

endmodule

@@ sv/inode_open_table.sv @@
// Top level of the reference-counted open inode table.
//
// The table keeps SLOTS entries, each a 16-bit reference count and the
// inode number it holds, in one synchronous memory with a separate read
// and write port and a registered read; a row of per-entry flags (cleared
// all at once by reset and by a clear, so there is no clearing pass) marks
// which entries are in use. One request is handled at a time. A get walks
// the memory from entry zero, one read a cycle, stopping at the first used
// entry that holds the inode; failing that it takes the lowest free entry
// seen during the walk. A get that misses and takes a new entry, and a put
// that reports write-back, also pass through the block and offset unit.
// The request port takes the next transfer as soon as the previous request
// has left for the result register, even if that result has not yet been
// taken downstream. The first_inode_block register sits at byte address 0
// of the configuration port and should be written only while the table is
// idle.
module inode_open_table #(
  parameter int SLOTS           = iot_pkg::SLOTS_DEF,
  parameter int INODES_IN_BLOCK = iot_pkg::INODES_IN_BLOCK_DEF,
  parameter int INODE_BYTES     = iot_pkg::INODE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // inode_number[9:0], slot[15:10]
  input  logic [1:0]  in_tuser,   // action[1:0]
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  // slot_out[5:0], inode_out[15:6], block_number[26:16], byte_offset[38:27], zero[39]
  output logic [39:0] out_tdata,
  output logic [2:0]  out_tuser,  // status[2:0]
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import iot_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam logic [BLOCK_W-1:0] FIRST_BLOCK_RST = 11'd3;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_PUT  = 5'b00100,
    S_LOC  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [INODE_W-1:0] inode;
  } entry_t;

  // Table memory.
  entry_t mem [SLOTS];
  entry_t rd_data_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  entry_t           mem_wd;
  logic [IDX_W-1:0] mem_ra;

  state_t state_r, state_nxt;
  logic [SLOTS-1:0]    used_r, used_nxt;
  logic [BLOCK_W-1:0]  first_blk_r;
  logic [INODE_W-1:0]  req_inode_r, req_inode_nxt;
  logic [CNT_W-1:0]    scan_cnt_r, scan_cnt_nxt;
  logic                pend_r, pend_nxt;
  logic [IDX_W-1:0]    pend_idx_r, pend_idx_nxt;
  logic                free_found_r, free_found_nxt;
  logic [IDX_W-1:0]    free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0]    put_idx_r, put_idx_nxt;
  logic                loc_start_r, loc_start_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic [INODE_W-1:0]  res_inode_r, res_inode_nxt;
  logic [BLOCK_W-1:0]  res_blk_r, res_blk_nxt;
  logic [OFFSET_W-1:0] res_off_r, res_off_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [39:0]         out_tdata_r, out_tdata_nxt;
  logic [2:0]          out_tuser_r, out_tuser_nxt;

  logic [ACT_W-1:0]    in_action;
  logic [INODE_W-1:0]  in_inode;
  logic [SLOT_W-1:0]   in_slot;
  logic [IDX_W-1:0]    in_put_idx;
  logic                in_put_ok;
  logic                in_xfer;
  logic                cfg_wr;

  logic                loc_done;
  logic [BLOCK_W-1:0]  loc_blk;
  logic [OFFSET_W-1:0] loc_off;

  assign in_action  = in_tuser;
  assign in_inode   = in_tdata[INODE_W-1:0];
  assign in_slot    = in_tdata[INODE_W +: SLOT_W];
  assign in_put_idx = IDX_W'(in_slot);
  assign in_put_ok  = (int'(in_slot) < SLOTS) && used_r[in_put_idx];
  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;

  // Register write on the access phase; only the word at address 0 exists.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : 32'(first_blk_r);

  iot_loc #(
    .INODES_IN_BLOCK (INODES_IN_BLOCK),
    .INODE_BYTES     (INODE_BYTES)
  ) u_loc (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (loc_start_r),
    .inode        (res_inode_r),
    .first_block  (first_blk_r),
    .done         (loc_done),
    .block_number (loc_blk),
    .byte_offset  (loc_off)
  );

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    req_inode_nxt  = req_inode_r;
    scan_cnt_nxt   = scan_cnt_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    put_idx_nxt    = put_idx_r;
    loc_start_nxt  = 1'b0;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_inode_nxt  = res_inode_r;
    res_blk_nxt    = res_blk_r;
    res_off_nxt    = res_off_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    mem_we         = 1'b0;
    mem_wa         = pend_idx_r;
    mem_wd         = rd_data_r;
    mem_ra         = scan_cnt_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        mem_ra      = in_put_idx;
        res_blk_nxt = '0;
        res_off_nxt = '0;
        if (in_xfer) begin
          case (in_action)
            ACT_GET: begin
              req_inode_nxt  = in_inode;
              scan_cnt_nxt   = '0;
              free_found_nxt = 1'b0;
              state_nxt      = S_SCAN;
            end
            ACT_PUT: begin
              if (in_put_ok) begin
                put_idx_nxt = in_put_idx;
                state_nxt   = S_PUT;
              end else begin
                res_status_nxt = ST_IGNORED;
                res_slot_nxt   = in_slot;
                res_inode_nxt  = '0;
                state_nxt      = S_EMIT;
              end
            end
            ACT_CLEAR: begin
              used_nxt       = '0;
              res_status_nxt = ST_CLEARED;
              res_slot_nxt   = '0;
              res_inode_nxt  = '0;
              state_nxt      = S_EMIT;
            end
            default: begin
              res_status_nxt = ST_IGNORED;
              res_slot_nxt   = '0;
              res_inode_nxt  = '0;
              state_nxt      = S_EMIT;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next read while the previous entry's data is checked.
        if (scan_cnt_r < CNT_W'(SLOTS)) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_cnt_r[IDX_W-1:0];
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
        if (pend_r) begin
          if (used_r[pend_idx_r] && rd_data_r.inode == req_inode_r) begin
            mem_we       = 1'b1;
            mem_wa       = pend_idx_r;
            mem_wd.inode = rd_data_r.inode;
            mem_wd.count = (rd_data_r.count == COUNT_MAX) ? COUNT_MAX
                                                          : rd_data_r.count + 1'b1;
            res_status_nxt = ST_HIT;
            res_slot_nxt   = SLOT_W'(pend_idx_r);
            res_inode_nxt  = req_inode_r;
            pend_nxt       = 1'b0;
            state_nxt      = S_EMIT;
          end else begin
            if (!used_r[pend_idx_r] && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_idx_nxt   = pend_idx_r;
            end
            if (pend_idx_r == IDX_W'(SLOTS - 1)) begin
              pend_nxt      = 1'b0;
              res_inode_nxt = req_inode_r;
              if (free_found_nxt) begin
                mem_we           = 1'b1;
                mem_wa           = free_idx_nxt;
                mem_wd.inode     = req_inode_r;
                mem_wd.count     = COUNT_W'(1);
                used_nxt[free_idx_nxt] = 1'b1;
                res_status_nxt   = ST_LOAD;
                res_slot_nxt     = SLOT_W'(free_idx_nxt);
                loc_start_nxt    = 1'b1;
                state_nxt        = S_LOC;
              end else begin
                res_status_nxt = ST_FULL;
                res_slot_nxt   = '0;
                state_nxt      = S_EMIT;
              end
            end
          end
        end
      end

      S_PUT: begin
        // The entry was read at the request transfer; count it down here.
        mem_we        = 1'b1;
        mem_wa        = put_idx_r;
        mem_wd.inode  = rd_data_r.inode;
        mem_wd.count  = rd_data_r.count - 1'b1;
        res_slot_nxt  = SLOT_W'(put_idx_r);
        res_inode_nxt = rd_data_r.inode;
        if (rd_data_r.count == COUNT_W'(1)) begin
          used_nxt[put_idx_r] = 1'b0;
          res_status_nxt      = ST_WB;
          loc_start_nxt       = 1'b1;
          state_nxt           = S_LOC;
        end else begin
          res_status_nxt = ST_OPEN;
          state_nxt      = S_EMIT;
        end
      end

      S_LOC: begin
        if (loc_done) begin
          res_blk_nxt = loc_blk;
          res_off_nxt = loc_off;
          state_nxt   = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = res_status_r;
          out_tdata_nxt  = {1'b0, res_off_r, res_blk_r, res_inode_r, res_slot_r};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_r       <= '0;
      first_blk_r  <= FIRST_BLOCK_RST;
      pend_r       <= 1'b0;
      loc_start_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      pend_r       <= pend_nxt;
      loc_start_r  <= loc_start_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr) begin
        first_blk_r <= cfg_pwdata[BLOCK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    req_inode_r  <= req_inode_nxt;
    scan_cnt_r   <= scan_cnt_nxt;
    pend_idx_r   <= pend_idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    put_idx_r    <= put_idx_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_inode_r  <= res_inode_nxt;
    res_blk_r    <= res_blk_nxt;
    res_off_r    <= res_off_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
